// ===== rtl/assert_macros.svh =====
// assertion macros shared by the block's checking code
// needs a signal named clock and a signal named reset where used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error(msg);

// property checked on every rising clock edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

// ===== rtl/spts_pkg.sv =====
// shared constants, payload types and codes of the servo pulse-train sequencer
// no dependencies
package spts_pkg;

   // channel count and derived widths
   localparam int CHANNELS = 8;
   localparam int ADDR_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int SLOT_W   = 4;
   localparam int PERIOD_W = 9;
   localparam int COUNT_W  = 13;
   localparam int SUM_W    = $clog2(CHANNELS * 499 + 1);

   // timing constants
   localparam logic [PERIOD_W-1:0] PERIOD_MIN    = 9'h0c7;
   localparam logic [PERIOD_W-1:0] PERIOD_MAX    = 9'h1f3;
   localparam logic [COUNT_W-1:0]  FRAME_TOTAL   = 13'd4999;
   localparam logic [COUNT_W-1:0]  COMPARE_POINT = 13'd128;
   localparam logic [COUNT_W-1:0]  START_TOP     = 13'd500;
   localparam logic [SUM_W-1:0]    SUM_RESET     = SUM_W'(CHANNELS * 199);

   // clamp limits
   localparam logic [7:0]         ANGLE_MAX  = 8'd180;
   localparam logic signed [15:0] MICROS_MIN = 16'sd1000;
   localparam logic signed [15:0] MICROS_MAX = 16'sd2000;

   // reciprocal multipliers: angle*5/3 as (angle*3415)>>11,
   // d*3/10 as (d*19662)>>16, both exact over the clamped ranges
   localparam logic [11:0] ANGLE_RECIP  = 12'd3415;
   localparam int          ANGLE_SHIFT  = 11;
   localparam logic [14:0] MICROS_RECIP = 15'd19662;
   localparam int          MICROS_SHIFT = 16;

   // operation codes
   localparam logic [1:0] OP_TICK   = 2'd0;
   localparam logic [1:0] OP_ANGLE  = 2'd1;
   localparam logic [1:0] OP_MICROS = 2'd2;

   // request payload
   typedef struct packed {
      logic [1:0]         operation;
      logic [7:0]         channel;
      logic [7:0]         angle;
      logic signed [15:0] micros;
   } req_type;

   // response payload
   typedef struct packed {
      logic              pulse_line;
      logic              frame_strobe;
      logic [SLOT_W-1:0] slot;
   } rsp_type;

endpackage

// ===== rtl/spts_if.sv =====
// channel interfaces of the servo pulse-train sequencer: request, response, csr write
// depends on spts_pkg
interface spts_req_if import spts_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [1:0]         operation;
   logic [7:0]         channel;
   logic [7:0]         angle;
   logic signed [15:0] micros;

   modport source (output valid, output operation, output channel, output angle,
                   output micros, input ready);
   modport sink   (input valid, input operation, input channel, input angle,
                   input micros, output ready);
endinterface

interface spts_rsp_if import spts_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              pulse_line;
   logic              frame_strobe;
   logic [SLOT_W-1:0] slot;

   modport source (output valid, output pulse_line, output frame_strobe, output slot,
                   input ready);
   modport sink   (input valid, input pulse_line, input frame_strobe, input slot,
                   output ready);
endinterface

interface spts_csr_if ();
   logic valid;
   logic ready;
   logic output_off;

   modport source (output valid, output output_off, input ready);
   modport sink   (input valid, input output_off, output ready);
endinterface

// ===== rtl/spts_ram.sv =====
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module spts_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic                                        rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/spts_map.sv =====
// maps an angle or a pulse length to a channel period, registered output
// depends on spts_pkg
module spts_map import spts_pkg::*; (
   input  logic                clock,
   input  req_type             item,
   output logic [PERIOD_W-1:0] period
);

   logic [7:0]         angle_clamp;
   logic [19:0]        angle_prod;
   logic signed [15:0] micros_clamp;
   logic [9:0]         micros_ofs;
   logic [24:0]        micros_prod;
   logic [PERIOD_W-1:0] period_in;
   logic [PERIOD_W-1:0] period_ff;

   // angle path: clamp to 180, scale by 5/3
   always_comb begin
      angle_clamp = (item.angle > ANGLE_MAX) ? ANGLE_MAX : item.angle;
      angle_prod  = 20'(angle_clamp) * 20'(ANGLE_RECIP);
   end

   // microsecond path: clamp to 1000..2000, scale offset by 3/10
   always_comb begin
      if (item.micros > MICROS_MAX) begin
         micros_clamp = MICROS_MAX;
      end else if (item.micros < MICROS_MIN) begin
         micros_clamp = MICROS_MIN;
      end else begin
         micros_clamp = item.micros;
      end
      micros_ofs  = 10'(micros_clamp - MICROS_MIN);
      micros_prod = 25'(micros_ofs) * 25'(MICROS_RECIP);
   end

   // pick by operation and add the minimum period
   always_comb begin
      if (item.operation == OP_ANGLE) begin
         period_in = PERIOD_W'(angle_prod >> ANGLE_SHIFT) + PERIOD_MIN;
      end else begin
         period_in = PERIOD_W'(micros_prod >> MICROS_SHIFT) + PERIOD_MIN;
      end
   end

   always_ff @(posedge clock) begin
      period_ff <= period_in;
   end

   assign period = period_ff;

endmodule

// ===== rtl/servo_pulse_train_sequencer.sv =====
// Servo pulse-train sequencer, top level.
// Channels: req carries one transaction per tick or period write (operation,
// channel, angle, micros); rsp returns one transaction per request with the
// pulse line level, the frame strobe and the running slot; csr writes the
// output_off bit and is always ready.
// Each request passes through accept, memory read and execute. The result
// enters the output register as the request leaves execute, so a new request
// is accepted only once the last one is through execute. This follows from
// the registered read of the period memory ahead of the read-modify-write.
// The sync gap uses a running sum of the periods kept beside the memory, so
// the sync slot needs no extra memory reads.
// Reset clears the counter, loads the start-up top of 500, marks every
// period entry as holding 199 through per-entry valid bits and empties the
// output register; no clearing pass is needed.
// A stalled receiver holds the result in the output register; a following
// request is still accepted and read, then waits in execute until the
// output register frees up.
// depends on spts_pkg, spts_if, spts_ram, spts_map, assert_macros.svh
`include "assert_macros.svh"

module servo_pulse_train_sequencer import spts_pkg::*; (
   input logic       clock,
   input logic       reset,
   spts_req_if.sink  req,
   spts_rsp_if.source rsp,
   spts_csr_if.sink  csr
);

   // sequencer states
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_READ = 2'd1;
   localparam logic [1:0] ST_EXEC = 2'd2;

   logic [1:0]          state_ff, state_in;
   req_type             item_ff;
   logic                output_off_ff;
   logic [COUNT_W-1:0]  tick_count_ff, tick_count_in;
   logic [COUNT_W-1:0]  period_top_ff, period_top_in;
   logic [SLOT_W-1:0]   slot_index_ff, slot_index_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [CHANNELS-1:0] valid_ff;
   logic                rd_valid_ff;
   logic                rsp_valid_ff;
   rsp_type             rsp_data_ff, rsp_data_in;

   logic                req_fire;
   logic                done;
   logic [7:0]          ch_m1;
   logic [ADDR_W-1:0]   pick_addr;
   logic [ADDR_W-1:0]   slot_addr;
   logic [ADDR_W-1:0]   rd_addr;
   logic [PERIOD_W-1:0] rd_data;
   logic [PERIOD_W-1:0] old_period;
   logic [PERIOD_W-1:0] new_period;
   logic                is_write;
   logic                wr_en;
   logic [SUM_W:0]      sum_wide;
   logic [COUNT_W:0]    sum_ext;
   logic [COUNT_W-1:0]  sync_top;
   logic                strobe;

   // handshakes
   assign req.ready = (state_ff == ST_IDLE);
   assign req_fire  = req.valid && req.ready;
   assign done      = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp.ready);
   assign csr.ready = 1'b1;

   // channel clamp to 1..CHANNELS, as a memory address
   always_comb begin
      if (item_ff.channel == 8'd0) begin
         ch_m1 = 8'd0;
      end else if (item_ff.channel > 8'(CHANNELS)) begin
         ch_m1 = 8'(CHANNELS - 1);
      end else begin
         ch_m1 = item_ff.channel - 8'd1;
      end
      pick_addr = ch_m1[ADDR_W-1:0];
      slot_addr = (slot_index_ff < SLOT_W'(CHANNELS)) ? slot_index_ff[ADDR_W-1:0]
                                                      : '0;
      rd_addr   = (item_ff.operation == OP_TICK) ? slot_addr : pick_addr;
   end

   // period memory
   spts_ram #(
      .WIDTH (PERIOD_W),
      .DEPTH (CHANNELS)
   ) u_period_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (pick_addr),
      .wr_data (new_period),
      .rd_en   (state_ff == ST_READ),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // angle and microsecond mapping
   spts_map u_map (
      .clock  (clock),
      .item   (item_ff),
      .period (new_period)
   );

   // sync top from the running sum, saturating at the minimum period
   always_comb begin
      sum_ext = (COUNT_W+1)'(sum_ff);
      if (sum_ext + (COUNT_W+1)'(PERIOD_MIN) > (COUNT_W+1)'(FRAME_TOTAL)) begin
         sync_top = COUNT_W'(PERIOD_MIN);
      end else begin
         sync_top = FRAME_TOTAL - sum_ext[COUNT_W-1:0];
      end
   end

   // execute: tick advance or period read-modify-write
   always_comb begin
      old_period    = rd_valid_ff ? rd_data : PERIOD_MIN;
      is_write      = (item_ff.operation == OP_ANGLE) || (item_ff.operation == OP_MICROS);
      wr_en         = done && is_write;
      tick_count_in = tick_count_ff;
      period_top_in = period_top_ff;
      slot_index_in = slot_index_ff;
      strobe        = 1'b0;
      sum_wide      = {1'b0, sum_ff} + (SUM_W+1)'(new_period) - (SUM_W+1)'(old_period);
      sum_in        = is_write ? sum_wide[SUM_W-1:0] : sum_ff;
      if (item_ff.operation == OP_TICK) begin
         if (tick_count_ff >= period_top_ff) begin
            tick_count_in = '0;
         end else begin
            tick_count_in = tick_count_ff + COUNT_W'(1);
         end
         if (tick_count_in == COMPARE_POINT) begin
            if (slot_index_ff < SLOT_W'(CHANNELS)) begin
               period_top_in = COUNT_W'(old_period);
               slot_index_in = slot_index_ff + SLOT_W'(1);
            end else begin
               period_top_in = sync_top;
               slot_index_in = '0;
               strobe        = 1'b1;
            end
         end
      end
      rsp_data_in.pulse_line   = !output_off_ff && (tick_count_in > COMPARE_POINT);
      rsp_data_in.frame_strobe = strobe;
      rsp_data_in.slot         = (slot_index_in == '0) ? SLOT_W'(CHANNELS)
                                                       : slot_index_in - SLOT_W'(1);
   end

   // state sequencing
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (done) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         output_off_ff <= 1'b0;
         tick_count_ff <= '0;
         period_top_ff <= START_TOP;
         slot_index_ff <= '0;
         sum_ff        <= SUM_RESET;
         valid_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr.valid) begin
            output_off_ff <= csr.output_off;
         end
         if (done) begin
            tick_count_ff <= tick_count_in;
            period_top_ff <= period_top_in;
            slot_index_ff <= slot_index_in;
            sum_ff        <= sum_in;
            rsp_valid_ff  <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (wr_en) begin
            valid_ff[pick_addr] <= 1'b1;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         item_ff.operation <= req.operation;
         item_ff.channel   <= req.channel;
         item_ff.angle     <= req.angle;
         item_ff.micros    <= req.micros;
      end
      if (state_ff == ST_READ) begin
         rd_valid_ff <= valid_ff[rd_addr];
      end
      if (done) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // response outputs
   assign rsp.valid        = rsp_valid_ff;
   assign rsp.pulse_line   = rsp_data_ff.pulse_line;
   assign rsp.frame_strobe = rsp_data_ff.frame_strobe;
   assign rsp.slot         = rsp_data_ff.slot;

   // checks
   `ASSERT_CLK(a_one_at_a_time, req_fire |=> !req.ready, "request accepted while busy")
   `ASSERT_CLK(a_strobe_slot, (rsp.valid && rsp.frame_strobe) |-> (rsp.slot == SLOT_W'(CHANNELS)), "frame strobe outside sync slot")
   `ASSERT_CLK(a_count_le_top, tick_count_ff <= period_top_ff, "tick counter passed its top")
   `ASSERT_ALWAYS(a_reset_idle, reset |=> (state_ff == ST_IDLE) && !rsp_valid_ff, "not idle after reset")

endmodule

// ===== dv/servo_pulse_train_sequencer_test.sv =====
// self-checking testbench for servo_pulse_train_sequencer: directed script, then random phases
// predicts each response transaction in a cycle-free model of the pulse train, unless a script row gives it
// depends on spts_pkg, spts_if and the rtl of the sequencer
module servo_pulse_train_sequencer_test;
   import spts_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // unused operation code, ignored by the block
   localparam logic [1:0] OP_UNUSED = 2'd3;

   localparam int IDLE_MAX     = 13;
   localparam int LONG_HOLD    = 300;
   localparam int HOLD_AT      = 150;
   localparam int PHASE_LEN    = 400;
   localparam int RANDOM_ITEMS = 2000;
   localparam int SETTLE_CYCLES = 10;
   localparam int QUIET_LIMIT  = 2000;
   localparam int SCRIPT_LEN   = 16;

   localparam rsp_type STARTUP_RSP = '{pulse_line: 1'b0, frame_strobe: 1'b0,
                                       slot: SLOT_W'(CHANNELS)};

   typedef struct {
      req_type item;
      bit      typed;
      rsp_type want;
   } script_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   spts_req_if req_ch ();
   spts_rsp_if rsp_ch ();
   spts_csr_if csr_ch ();

   servo_pulse_train_sequencer DUT (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch),
      .csr   (csr_ch)
   );

   // model state of the pulse train
   logic [PERIOD_W-1:0] period_mem [CHANNELS];
   logic [COUNT_W-1:0]  tick_ctr;
   logic [COUNT_W-1:0]  top_ctr;
   logic [SLOT_W-1:0]   next_slot;
   logic                line_off;

   rsp_type expected_q [$];
   int      idle_max = IDLE_MAX;
   int      mismatch_count;
   int      results_seen;
   int      quiet_cycles;

   // directed script: extremes of every field, every operation, clamps
   script_row_type startup_script [SCRIPT_LEN] = '{
      '{'{OP_TICK,   8'd0,   8'd0,   16'sd0},     1'b1, STARTUP_RSP},
      '{'{OP_ANGLE,  8'd0,   8'd0,   16'sd0},     1'b1, STARTUP_RSP},
      '{'{OP_ANGLE,  8'd255, 8'd255, 16'sd0},     1'b1, STARTUP_RSP},
      '{'{OP_ANGLE,  8'd8,   8'd180, 16'sd0},     1'b1, STARTUP_RSP},
      '{'{OP_ANGLE,  8'd3,   8'd181, 16'sd0},     1'b1, STARTUP_RSP},
      '{'{OP_ANGLE,  8'd4,   8'd91,  16'sd0},     1'b0, STARTUP_RSP},
      '{'{OP_MICROS, 8'd2,   8'd0,   16'sh8000},  1'b1, STARTUP_RSP},
      '{'{OP_MICROS, 8'd5,   8'd0,   16'sh7fff},  1'b1, STARTUP_RSP},
      '{'{OP_MICROS, 8'd6,   8'd0,   16'sd999},   1'b1, STARTUP_RSP},
      '{'{OP_MICROS, 8'd7,   8'd0,   16'sd2001},  1'b1, STARTUP_RSP},
      '{'{OP_MICROS, 8'd9,   8'd0,   16'sd1000},  1'b0, STARTUP_RSP},
      '{'{OP_MICROS, 8'd1,   8'd0,   16'sd1733},  1'b0, STARTUP_RSP},
      '{'{OP_UNUSED, 8'd255, 8'd255, -16'sd1},    1'b1, STARTUP_RSP},
      '{'{OP_TICK,   8'd255, 8'd255, -16'sd1},    1'b0, STARTUP_RSP},
      '{'{OP_ANGLE,  8'd0,   8'd255, 16'sd0},     1'b0, STARTUP_RSP},
      '{'{OP_TICK,   8'd0,   8'd0,   16'sd0},     1'b0, STARTUP_RSP}
   };

   // clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // servo number clamped to a memory index
   function automatic int servo_index(input logic [7:0] servo);
      if (servo < 8'd1) return 0;
      if (servo > CHANNELS) return CHANNELS - 1;
      return int'(servo) - 1;
   endfunction

   // advance the pulse train by one request and return its response
   function automatic rsp_type advance_sequencer(input req_type item);
      rsp_type     res;
      int unsigned deg;
      int          us;
      int unsigned total;
      res.frame_strobe = 1'b0;
      case (item.operation)
         OP_TICK: begin
            if (tick_ctr >= top_ctr) tick_ctr = '0;
            else tick_ctr = tick_ctr + 1'b1;
            // compare point reached: load the next top
            if (tick_ctr == COMPARE_POINT) begin
               if (next_slot < CHANNELS) begin
                  top_ctr   = COUNT_W'(period_mem[next_slot]);
                  next_slot = next_slot + 1'b1;
               end else begin
                  // sync gap fills the frame, saturating at the minimum
                  total = 0;
                  foreach (period_mem[i]) total += period_mem[i];
                  if (total + PERIOD_MIN > FRAME_TOTAL) top_ctr = COUNT_W'(PERIOD_MIN);
                  else top_ctr = FRAME_TOTAL - COUNT_W'(total);
                  next_slot        = '0;
                  res.frame_strobe = 1'b1;
               end
            end
         end
         OP_ANGLE: begin
            deg = item.angle;
            if (deg > ANGLE_MAX) deg = ANGLE_MAX;
            period_mem[servo_index(item.channel)] =
               PERIOD_W'(deg * (PERIOD_MAX - PERIOD_MIN) / ANGLE_MAX + PERIOD_MIN);
         end
         OP_MICROS: begin
            us = item.micros;
            if (us > MICROS_MAX) us = MICROS_MAX;
            if (us < MICROS_MIN) us = MICROS_MIN;
            period_mem[servo_index(item.channel)] =
               PERIOD_W'((us - int'(MICROS_MIN)) * int'(PERIOD_MAX - PERIOD_MIN)
                         / int'(MICROS_MAX - MICROS_MIN) + int'(PERIOD_MIN));
         end
         default: ;
      endcase
      res.pulse_line = !line_off && (tick_ctr > COMPARE_POINT);
      res.slot       = (next_slot == '0) ? SLOT_W'(CHANNELS) : next_slot - 1'b1;
      return res;
   endfunction

   // offer one request transaction after a random gap, record what it should return
   task automatic offer_request(input req_type item, input bit typed, input rsp_type want);
      int      gap;
      rsp_type predicted;
      gap = $urandom_range(0, idle_max);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.operation <= item.operation;
      req_ch.channel   <= item.channel;
      req_ch.angle     <= item.angle;
      req_ch.micros    <= item.micros;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      predicted = advance_sequencer(item);
      expected_q.push_back(typed ? want : predicted);
   endtask

   // stop offering and wait until every response is back
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
   endtask

   // csr write transaction, only while the block is idle
   task automatic write_output_off(input logic value);
      csr_ch.valid      <= 1'b1;
      csr_ch.output_off <= value;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      line_off = value;
      csr_ch.valid <= 1'b0;
   endtask

   // response side: random stalls, one long hold-off, field checks
   initial begin
      int      stall;
      rsp_type got;
      rsp_type want;
      rsp_ch.ready <= 1'b0;
      @(negedge reset);
      forever begin
         stall = (results_seen == HOLD_AT) ? LONG_HOLD : $urandom_range(0, idle_max);
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_ch.valid) @(posedge clock);
         got = '{rsp_ch.pulse_line, rsp_ch.frame_strobe, rsp_ch.slot};
         results_seen++;
         if (expected_q.size() == 0) begin
            $error("response transaction with nothing expected: %p", got);
            mismatch_count++;
         end else begin
            want = expected_q.pop_front();
            if (got.pulse_line !== want.pulse_line) begin
               $error("pulse_line expected %0d got %0d", want.pulse_line, got.pulse_line);
               mismatch_count++;
            end
            if (got.frame_strobe !== want.frame_strobe) begin
               $error("frame_strobe expected %0d got %0d", want.frame_strobe,
                      got.frame_strobe);
               mismatch_count++;
            end
            if (got.slot !== want.slot) begin
               $error("slot expected %0d got %0d", want.slot, got.slot);
               mismatch_count++;
            end
         end
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
          || (csr_ch.valid && csr_ch.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
         $display("[servo_pulse_train_sequencer] ERROR");
         $finish;
      end
   end

   // stimulus
   initial begin
      req_type item;
      int      pick;
      int      random_count;
      int      phase;
      req_ch.valid      <= 1'b0;
      req_ch.operation  <= OP_TICK;
      req_ch.channel    <= '0;
      req_ch.angle      <= '0;
      req_ch.micros     <= '0;
      csr_ch.valid      <= 1'b0;
      csr_ch.output_off <= 1'b0;

      // model reset
      foreach (period_mem[i]) period_mem[i] = PERIOD_MIN;
      tick_ctr  = '0;
      top_ctr   = START_TOP;
      next_slot = '0;
      line_off  = 1'b0;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      write_output_off(1'b0);

      // directed script
      foreach (startup_script[i])
         offer_request(startup_script[i].item, startup_script[i].typed,
                       startup_script[i].want);

      // random phases, mostly ticks
      random_count = 0;
      phase        = 0;
      while (random_count < RANDOM_ITEMS) begin
         wait_drained();
         idle_max = (phase % 3 == 2) ? 0 : IDLE_MAX;
         write_output_off(phase % 2 == 0);
         repeat (PHASE_LEN) begin
            pick = $urandom_range(0, 99);
            if (pick < 80) item.operation = OP_TICK;
            else if (pick < 88) item.operation = OP_ANGLE;
            else if (pick < 97) item.operation = OP_MICROS;
            else item.operation = OP_UNUSED;
            item.channel = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(1, CHANNELS))
                                                      : 8'($urandom_range(0, 255));
            item.angle   = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 180))
                                                      : 8'($urandom_range(0, 255));
            item.micros  = ($urandom_range(0, 9) < 6) ? 16'($urandom_range(900, 2100))
                                                      : 16'($urandom);
            offer_request(item, 1'b0, STARTUP_RSP);
         end
         random_count += PHASE_LEN;
         phase++;
      end

      // drain and settle
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_q.size() != 0) begin
         $error("%0d response transactions never arrived", expected_q.size());
         mismatch_count++;
      end
      if (mismatch_count == 0)
         $display("[servo_pulse_train_sequencer] OK");
      else
         $display("[servo_pulse_train_sequencer] ERROR");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/spts_pkg.sv
rtl/spts_if.sv
rtl/spts_ram.sv
rtl/spts_map.sv
rtl/servo_pulse_train_sequencer.sv
dv/servo_pulse_train_sequencer_test.sv
